// ----- rtl/sfcf_pkg.sv -----
`timescale 1ns / 1ps

package sfcf_pkg;

  typedef logic signed [23:0] sample_t;
  typedef logic signed [31:0] acc_t;
  typedef logic signed [21:0] ring_t;
  typedef logic [14:0]        mix_t;
  typedef logic [33:0]        wet_gain_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CFG_ARMED    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIX_GAIN = 2'd1;

  localparam mix_t MIX_DEFAULT = 15'd8192;
  localparam mix_t MIX_LIMIT   = 15'd20480;

  localparam logic signed [20:0] K_FB  = 21'sd576717;
  localparam logic signed [20:0] K_DRY = 21'sd754975;
  localparam logic [19:0]        K_WET = 20'd681574;

  localparam logic signed [25:0] K_CLAMP = 26'sd1572864;
  localparam logic signed [25:0] K_ZERO  = 26'sd4194304;

  localparam wet_gain_t WET_GAIN_RESET = 34'(MIX_DEFAULT) * 34'(K_WET);

  function automatic mix_t eff_mix(input mix_t m);
    if (m == '0 || m >= MIX_LIMIT) begin
      return MIX_DEFAULT;
    end
    return m;
  endfunction

  // zero at or beyond +-4.0, then clamp to +-1.5
  function automatic ring_t limit_store(input logic signed [25:0] s);
    if (s >= K_ZERO || s <= -K_ZERO) begin
      return '0;
    end
    if (s > K_CLAMP) begin
      return K_CLAMP[21:0];
    end
    if (s < -K_CLAMP) begin
      return ring_t'(-K_CLAMP);
    end
    return s[21:0];
  endfunction

  function automatic acc_t sat32(input logic signed [32:0] s);
    if (s[32] != s[31]) begin
      return {s[32], {31{~s[32]}}};
    end
    return s[31:0];
  endfunction

endpackage

// ----- rtl/stereo_feedback_comb_filter.sv -----
`timescale 1ns / 1ps

// Stereo feedback comb filter. Takes one frame (left and right samples plus
// both running accumulators) per clock while in_stall_o is low and presents
// the updated accumulators, saturated, from the result register after the
// frame has passed through the input register; with the downstream side
// taking every item, one frame completes every cycle. The delay ring is a
// single-port-per-side memory of RING_DEPTH entries: the entry for a frame is
// read from it as the frame enters the input register and the new value is
// written back as the frame moves on to the output register, so frames
// follow each other without gaps. After reset the ring reads as zero until
// the pointer has gone once around it; no clearing pass is needed. With
// armed at 0 the ring and pointer are left alone and each accumulator only
// adds its own sample. Write configuration only while no item is in flight.
module stereo_feedback_comb_filter #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [sfcf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfcf_pkg::CfgDataW-1:0]  cfg_wdata_i,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sfcf_pkg::sample_t              in_left_i,
  input  sfcf_pkg::sample_t              in_right_i,
  input  sfcf_pkg::acc_t                 acc_left_i,
  input  sfcf_pkg::acc_t                 acc_right_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sfcf_pkg::acc_t                 out_left_o,
  output sfcf_pkg::acc_t                 out_right_o
);

  import sfcf_pkg::*;

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  logic      armed_q;
  wet_gain_t wet_gain_q;

  logic            in_valid_q;
  sample_t         in_l_q, in_r_q;
  acc_t            acc_l_q, acc_r_q;
  logic [PtrW-1:0] wr_addr_q;
  ring_t           rd_data_q;
  logic            rd_fill_q;

  logic [PtrW-1:0] ptr_q;
  logic            filled_q;

  ring_t ring_mem [RING_DEPTH];

  logic out_valid_q;
  acc_t out_l_q, out_r_q;

  logic in_accept;
  logic move;

  ring_t                delayed;
  logic signed [24:0]   lr_sum;
  logic signed [23:0]   mono;
  logic signed [42:0]   fb_prod;
  logic signed [42:0]   fb_round;
  logic signed [22:0]   fb;
  logic signed [25:0]   store_raw;
  ring_t                store;
  logic signed [44:0]   dry_l, dry_r;
  logic signed [56:0]   wet;
  logic signed [59:0]   sum_l, sum_r;
  logic signed [25:0]   ol, orr;
  acc_t                 res_l, res_r;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      wet_gain_q <= WET_GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ARMED:    armed_q    <= cfg_wdata_i[0];
        CFG_MIX_GAIN: wet_gain_q <= 34'(eff_mix(cfg_wdata_i)) * 34'(K_WET);
        default:      ;
      endcase
    end
  end

  assign move       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !move;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register and ring pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      ptr_q      <= '0;
      filled_q   <= 1'b0;
      rd_fill_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (in_accept && armed_q) begin
        rd_fill_q <= filled_q;
        if (ptr_q == PtrLast) begin
          ptr_q    <= '0;
          filled_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_l_q    <= in_left_i;
      in_r_q    <= in_right_i;
      acc_l_q   <= acc_left_i;
      acc_r_q   <= acc_right_i;
      wr_addr_q <= ptr_q;
    end
  end

  // delay ring
  always_ff @(posedge clk_i) begin
    if (move && armed_q) begin
      ring_mem[wr_addr_q] <= store;
    end
    if (in_accept && armed_q) begin
      rd_data_q <= ring_mem[ptr_q];
    end
  end

  // stored values are already limited, so the read needs no limiting
  assign delayed = rd_fill_q ? rd_data_q : '0;

  always_comb begin
    lr_sum    = 25'(in_l_q) + 25'(in_r_q);
    mono      = lr_sum[24:1];
    fb_prod   = 43'(delayed) * 43'(K_FB);
    fb_round  = fb_prod + 43'sd524288;
    fb        = fb_round[42:20];
    store_raw = 26'(mono) + 26'(fb);
    store     = limit_store(store_raw);

    dry_l = 45'(in_l_q) * 45'(K_DRY);
    dry_r = 45'(in_r_q) * 45'(K_DRY);
    wet   = 57'(delayed) * $signed({23'b0, wet_gain_q});
    sum_l = (60'(dry_l) <<< 14) + 60'(wet) + (60'sd1 <<< 33);
    sum_r = (60'(dry_r) <<< 14) + 60'(wet) + (60'sd1 <<< 33);
    ol    = sum_l[59:34];
    orr   = sum_r[59:34];

    if (armed_q) begin
      res_l = sat32(33'(acc_l_q) + 33'(ol));
      res_r = sat32(33'(acc_r_q) + 33'(orr));
    end else begin
      res_l = sat32(33'(acc_l_q) + 33'(in_l_q));
      res_r = sat32(33'(acc_r_q) + 33'(in_r_q));
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_l_q <= res_l;
      out_r_q <= res_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled while result path is free");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && armed_q && ptr_q != PtrLast) |=> (ptr_q == PtrW'($past(ptr_q) + 1'b1)))
    else $error("ring pointer did not advance by one");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_accept && armed_q)) |=> $stable(ptr_q))
    else $error("ring pointer moved without an armed item");

  a_fill_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("ring fill flag dropped");

endmodule

// ----- dv/tb_stereo_feedback_comb_filter.sv -----
`timescale 1ns / 1ps

module tb_stereo_feedback_comb_filter;

  localparam int DEPTH = 16;
  localparam int STUCK_LIMIT = 2000;
  localparam int IDLE_PCT = 29;
  localparam int PHASE_ITEMS = 150;

  localparam longint FB_Q20 = 576717;
  localparam longint DRY_Q20 = 754975;
  localparam longint WET_Q20 = 681574;
  localparam longint CLAMP_Q20 = 1572864;
  localparam longint ZERO_Q20 = 4194304;

  localparam logic [sfcf_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [sfcf_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    sfcf_pkg::sample_t left;
    sfcf_pkg::sample_t right;
    sfcf_pkg::acc_t    acc_l;
    sfcf_pkg::acc_t    acc_r;
  } frame_t;

  typedef struct {
    sfcf_pkg::acc_t left;
    sfcf_pkg::acc_t right;
  } sums_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_we_i = 1'b0;
  logic [sfcf_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [sfcf_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  sfcf_pkg::sample_t in_left_i = '0;
  sfcf_pkg::sample_t in_right_i = '0;
  sfcf_pkg::acc_t    acc_left_i = '0;
  sfcf_pkg::acc_t    acc_right_i = '0;

  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  sfcf_pkg::acc_t out_left_o;
  sfcf_pkg::acc_t out_right_o;

  logic signed [21:0] ring_m [DEPTH] = '{default: '0};
  int unsigned        ring_ptr = 0;
  logic               armed_m = 1'b0;
  sfcf_pkg::mix_t     mix_m = sfcf_pkg::MIX_DEFAULT;

  frame_t pending_frames[$];
  sums_t  expected_sums[$];
  int     err_cnt = 0;
  int     stuck_cycles = 0;
  bit     no_idle = 1'b0;

  stereo_feedback_comb_filter #(.RING_DEPTH(DEPTH)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint limit_ring(longint v);
    if (v >= ZERO_Q20 || v <= -ZERO_Q20) begin
      return 0;
    end
    if (v > CLAMP_Q20) begin
      return CLAMP_Q20;
    end
    if (v < -CLAMP_Q20) begin
      return -CLAMP_Q20;
    end
    return v;
  endfunction

  function automatic sfcf_pkg::acc_t clip32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // advances the ring state on armed frames
  function automatic sums_t comb_step(frame_t f);
    longint l, r, mix, mono, delayed, store, wet;
    sums_t s;
    l = f.left;
    r = f.right;
    if (!armed_m) begin
      s.left = clip32(longint'(f.acc_l) + l);
      s.right = clip32(longint'(f.acc_r) + r);
      return s;
    end
    if (mix_m == '0 || mix_m >= sfcf_pkg::MIX_LIMIT) begin
      mix = sfcf_pkg::MIX_DEFAULT;
    end else begin
      mix = mix_m;
    end
    mono = (l + r) >>> 1;
    delayed = limit_ring(ring_m[ring_ptr]);
    store = limit_ring(mono + ((delayed * FB_Q20 + (64'sd1 <<< 19)) >>> 20));
    ring_m[ring_ptr] = store[21:0];
    ring_ptr = (ring_ptr == DEPTH - 1) ? 0 : ring_ptr + 1;
    wet = delayed * mix * WET_Q20;
    s.left = clip32(longint'(f.acc_l) + ((l * DRY_Q20 * 16384 + wet + (64'sd1 <<< 33)) >>> 34));
    s.right = clip32(longint'(f.acc_r) + ((r * DRY_Q20 * 16384 + wet + (64'sd1 <<< 33)) >>> 34));
    return s;
  endfunction

  function automatic sfcf_pkg::sample_t rand_sample();
    case ($urandom_range(4))
      0: return sfcf_pkg::sample_t'($urandom);
      1: return sfcf_pkg::sample_t'(int'($urandom_range(4194304)) - 2097152);
      2: return sfcf_pkg::sample_t'(int'($urandom_range(8388608)) - 4194304);
      3: begin
        if ($urandom_range(1)) begin
          return 24'sh7fffff - sfcf_pkg::sample_t'($urandom_range(15));
        end
        return 24'sh800000 + sfcf_pkg::sample_t'($urandom_range(15));
      end
      default: return sfcf_pkg::sample_t'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic sfcf_pkg::acc_t rand_acc();
    case ($urandom_range(3))
      0: return sfcf_pkg::acc_t'($urandom);
      1: return sfcf_pkg::acc_t'(32'h7fffffff - $urandom_range(8388607));
      2: return sfcf_pkg::acc_t'(32'h80000000 + $urandom_range(8388607));
      default: return sfcf_pkg::acc_t'(int'($urandom_range(33554432)) - 16777216);
    endcase
  endfunction

  task automatic push_frame(sfcf_pkg::sample_t l, sfcf_pkg::sample_t r,
                            sfcf_pkg::acc_t al, sfcf_pkg::acc_t ar);
    frame_t f;
    f.left = l;
    f.right = r;
    f.acc_l = al;
    f.acc_r = ar;
    pending_frames.push_back(f);
  endtask

  task automatic write_reg(logic [sfcf_pkg::CfgIdxW-1:0] idx,
                           logic [sfcf_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sfcf_pkg::CFG_ARMED:    armed_m = data[0];
      sfcf_pkg::CFG_MIX_GAIN: mix_m = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_frames.size() != 0 || expected_sums.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_test();
    sfcf_pkg::mix_t mix_tab [8];
    bit             armed_tab [8];
    mix_tab = '{15'd1, 15'd0, 15'd20480, 15'd20479, 15'd12000, 15'd32767, 15'd16384, 15'd0};
    mix_tab[7] = sfcf_pkg::mix_t'($urandom_range(20479, 1));
    armed_tab = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pass-through add after reset
    @(negedge clk_i);
    push_frame('0, '0, '0, '0);
    push_frame(24'sh7fffff, 24'sh7fffff, 32'sh7fffffff, 32'sh7fffffff);
    push_frame(24'sh800000, 24'sh800000, 32'sh80000000, 32'sh80000000);
    push_frame(-24'sd1, 24'sd1, 32'sh7fffffff, 32'sh80000000);
    push_frame(24'sh7fffff, 24'sh800000, '0, '0);
    drain();

    // armed with the reset mix, spare indexes must not disturb anything
    write_reg(sfcf_pkg::CFG_ARMED, 15'd1);
    write_reg(CFG_SPARE_LO, sfcf_pkg::mix_t'($urandom));
    write_reg(CFG_SPARE_HI, sfcf_pkg::mix_t'($urandom));
    @(negedge clk_i);
    push_frame(24'sh7fffff, 24'sh7fffff, 32'sh7fffffff, 32'sh7fffffff);
    push_frame(24'sh800000, 24'sh800000, 32'sh80000000, 32'sh80000000);
    push_frame(24'sd2097152, 24'sd2097152, '0, '0);
    push_frame(-24'sd2097152, -24'sd2097152, '0, '0);
    push_frame(24'sd4194303, 24'sd4194303, '0, '0);
    push_frame(24'sd4194304, 24'sd4194304, '0, '0);
    push_frame(-24'sd4194303, -24'sd4194303, '0, '0);
    push_frame(-24'sd4194304, -24'sd4194304, '0, '0);
    push_frame(24'sd1572864, 24'sd1572864, '0, '0);
    push_frame(24'sd1572865, 24'sd1572865, '0, '0);
    push_frame(24'sd1, 24'sd0, '0, '0);
    push_frame(-24'sd1, 24'sd0, '0, '0);
    // wrap the pointer so stored values come back around
    for (int i = 0; i < 8; i++) begin
      push_frame(rand_sample(), rand_sample(), rand_acc(), rand_acc());
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(sfcf_pkg::CFG_ARMED, 15'(armed_tab[p]));
      write_reg(sfcf_pkg::CFG_MIX_GAIN, mix_tab[p]);
      @(negedge clk_i);
      no_idle = (p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_frame(rand_sample(), rand_sample(), rand_acc(), rand_acc());
      end
      drain();
    end
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : frame_driver
    frame_t f;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        f.left = in_left_i;
        f.right = in_right_i;
        f.acc_l = acc_left_i;
        f.acc_r = acc_right_i;
        expected_sums.push_back(comb_step(f));
      end
      if (pending_frames.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        f = pending_frames.pop_front();
        in_left_i <= f.left;
        in_right_i <= f.right;
        acc_left_i <= f.acc_l;
        acc_right_i <= f.acc_r;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : sums_monitor
    sums_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected item: out_left %0d out_right %0d", out_left_o, out_right_o);
          err_cnt++;
        end else begin
          want = expected_sums.pop_front();
          if (out_left_o !== want.left) begin
            $error("out_left: expected %0d, got %0d", want.left, out_left_o);
            err_cnt++;
          end
          if (out_right_o !== want.right) begin
            $error("out_right: expected %0d, got %0d", want.right, out_right_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : test_ctrl
    fork
      run_test();
      wait (stuck_cycles >= STUCK_LIMIT);
    join_any
    disable fork;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $error("no item moved for %0d cycles", stuck_cycles);
    end
    if (expected_sums.size() != 0) begin
      $error("%0d expected items never arrived", expected_sums.size());
    end
    if (stuck_cycles < STUCK_LIMIT && err_cnt == 0 && expected_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfcf_pkg.sv
rtl/stereo_feedback_comb_filter.sv
dv/tb_stereo_feedback_comb_filter.sv
